// ----- hw/rtl/xtea_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and helper functions of the XTEA pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  // one pipeline stage per half-round
  localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_WORD_ZERO  = 2'd0,
    KEY_WORD_ONE   = 2'd1,
    KEY_WORD_TWO   = 2'd2,
    KEY_WORD_THREE = 2'd3
  } reg_idx_e;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } blk_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // running sum seen by half-round stage j, elaboration constant
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned j, input logic dec);
    logic [63:0] prod;
    int unsigned n;
    n    = dec ? (ROUND_COUNT - ((j + 1) >> 1)) : ((j + 1) >> 1);
    prod = 64'(n) * 64'(DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/xtea_key_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_key_regs
// Four 32-bit key registers behind a plain write port.
// ----------------------------------------------------------------------------
module xtea_key_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]    cfg_wdata_i,
  output xtea_pkg::key_t                      key_o
);
  import xtea_pkg::*;

  key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        KEY_WORD_ZERO:  key_d[0] = cfg_wdata_i;
        KEY_WORD_ONE:   key_d[1] = cfg_wdata_i;
        KEY_WORD_TWO:   key_d[2] = cfg_wdata_i;
        KEY_WORD_THREE: key_d[3] = cfg_wdata_i;
        default:        key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule
`default_nettype wire

// ----- hw/rtl/xtea_half_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_half_round
// One registered half-round: updates one block word from the other.
// ----------------------------------------------------------------------------
module xtea_half_round (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        odd_stage_i,
  input  wire logic [xtea_pkg::WORD_W-1:0] sum_enc_i,
  input  wire logic [xtea_pkg::WORD_W-1:0] sum_dec_i,
  input  wire xtea_pkg::key_t              key_i,
  input  wire xtea_pkg::blk_t              blk_i,
  output xtea_pkg::blk_t                   blk_o
);
  import xtea_pkg::*;

  logic              dec;
  logic              upd_first;
  logic [WORD_W-1:0] sum;
  logic [1:0]        key_sel;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] term;
  logic [WORD_W-1:0] res;
  blk_t              blk_d;
  logic              valid_q;
  logic              op_q;
  logic [WORD_W-1:0] v0_q, v1_q;

  assign dec = (blk_i.op == OP_DECRYPT);
  // encrypt updates v0 on even stages, decrypt on odd ones
  assign upd_first = (dec == odd_stage_i);
  assign sum       = dec ? sum_dec_i : sum_enc_i;
  assign key_sel   = upd_first ? sum[1:0] : sum[12:11];
  assign src       = upd_first ? blk_i.v1 : blk_i.v0;
  assign dst       = upd_first ? blk_i.v0 : blk_i.v1;
  assign term      = mix(src) ^ (sum + key_i[key_sel]);
  assign res       = dec ? (dst - term) : (dst + term);

  always_comb begin
    blk_d = blk_i;
    if (upd_first) begin
      blk_d.v0 = res;
    end else begin
      blk_d.v1 = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= blk_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= blk_d.op;
    v0_q <= blk_d.v0;
    v1_q <= blk_d.v1;
  end

  assign blk_o = '{valid: valid_q, op: op_q, v0: v0_q, v1: v1_q};

endmodule
`default_nettype wire

// ----- hw/rtl/xtea_block_cipher_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_block_cipher_top
// XTEA block cipher (ECB), one 64-bit block per clock, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   - key: four 32-bit words written through cfg_we_i / cfg_idx_i /
//     cfg_wdata_i, index 0..3 for key words k[0]..k[3]; write only while
//     no transaction is in flight
//   - input: a transaction is taken at each edge with start_i high and
//     busy_o low; busy_o is always low, so a block may enter every cycle
//   - opcode_i 0 encrypts, 1 decrypts first_word_i / second_word_i
//   - output: valid_o is high for one cycle with first_result_o and
//     second_result_o; results leave in input order
//   - pipeline: one register per half-round between acceptance and
//     valid_o
//   - throughput: one block per cycle, set by the 64-stage round pipeline
//   - reset: clears the key to zero and empties the pipeline; blocks in
//     flight are dropped
//   - the receiver cannot stall; each result is presented exactly once
// ----------------------------------------------------------------------------
module xtea_block_cipher_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]    cfg_wdata_i,
  input  wire logic                           start_i,
  output      logic                           busy_o,
  input  wire logic                           opcode_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]    first_word_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]    second_word_i,
  output      logic                           valid_o,
  output      logic [xtea_pkg::WORD_W-1:0]    first_result_o,
  output      logic [xtea_pkg::WORD_W-1:0]    second_result_o
);
  import xtea_pkg::*;

  key_t key;
  blk_t chain [STAGE_COUNT+1];

  xtea_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  assign busy_o = 1'b0;

  assign chain[0] = '{valid: start_i & ~busy_o, op: opcode_i,
                      v0: first_word_i, v1: second_word_i};

  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
    xtea_half_round u_half_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .odd_stage_i (1'(g % 2)),
      .sum_enc_i   (round_sum(g, 1'b0)),
      .sum_dec_i   (round_sum(g, 1'b1)),
      .key_i       (key),
      .blk_i       (chain[g]),
      .blk_o       (chain[g+1])
    );
  end

  assign valid_o         = chain[STAGE_COUNT].valid;
  assign first_result_o  = chain[STAGE_COUNT].v0;
  assign second_result_o = chain[STAGE_COUNT].v1;

endmodule
`default_nettype wire

// ----- test/xtea_block_cipher_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xtea_block_cipher_top_tb
// Self-checking bench for the XTEA ECB pipeline. Blocks are sent in random
// bursts under several keys. Each result is compared with a cipher
// computed inside the bench, in the order the blocks were sent.
// ----------------------------------------------------------------------------
module xtea_block_cipher_top_tb;
  import xtea_pkg::*;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } cipher_block_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  word_t                cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic                 opcode_i;
  word_t                first_word_i;
  word_t                second_word_i;
  logic                 valid_o;
  word_t                first_result_o;
  word_t                second_result_o;

  word_t         key_copy [KEY_WORDS];
  cipher_block_t pending_blocks [$];
  int unsigned   error_count;

  xtea_block_cipher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .first_word_i   (first_word_i),
    .second_word_i  (second_word_i),
    .valid_o        (valid_o),
    .first_result_o (first_result_o),
    .second_result_o(second_result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic word_t feistel_f(word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic cipher_block_t xtea_predict(op_e op, word_t v0, word_t v1);
    word_t         sum;
    cipher_block_t blk;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        v0  = v0 + (feistel_f(v1) ^ (sum + key_copy[sum[1:0]]));
        sum = sum + DELTA;
        v1  = v1 + (feistel_f(v0) ^ (sum + key_copy[sum[12:11]]));
      end
    end else begin
      // start of the reversed schedule, the sum after the last cycle
      sum = word_t'(ROUND_COUNT) * DELTA;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        v1  = v1 - (feistel_f(v0) ^ (sum + key_copy[sum[12:11]]));
        sum = sum - DELTA;
        v0  = v0 - (feistel_f(v1) ^ (sum + key_copy[sum[1:0]]));
      end
    end
    blk.first  = v0;
    blk.second = v1;
    return blk;
  endfunction

  // biased toward the corners of the word
  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return $urandom();
    endcase
  endfunction

  // checker: results are stable across the cycle, sampled mid-cycle
  always @(negedge clk_i) begin
    cipher_block_t exp_blk;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result %h %h", first_result_o, second_result_o);
        error_count++;
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (first_result_o !== exp_blk.first) begin
          $error("first_result expected %h actual %h", exp_blk.first, first_result_o);
          error_count++;
        end
        if (second_result_o !== exp_blk.second) begin
          $error("second_result expected %h actual %h", exp_blk.second, second_result_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_block(op_e op, word_t w0, word_t w1);
    start_i       <= 1'b1;
    opcode_i      <= op;
    first_word_i  <= w0;
    second_word_i <= w1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_blocks.push_back(xtea_predict(op, w0, w1));
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      if (start_i) start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    if (start_i) start_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_key_word(reg_idx_e idx, word_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    key_copy[idx] = value;
  endtask

  // only called with the pipeline empty
  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_key_word(KEY_WORD_ZERO, k0);
    write_key_word(KEY_WORD_ONE, k1);
    write_key_word(KEY_WORD_TWO, k2);
    write_key_word(KEY_WORD_THREE, k3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_round_trip(word_t w0, word_t w1);
    cipher_block_t ct;
    ct = xtea_predict(OP_ENCRYPT, w0, w1);
    send_block(OP_ENCRYPT, w0, w1);
    send_block(OP_DECRYPT, ct.first, ct.second);
  endtask

  task automatic run_traffic(int unsigned count, int unsigned max_gap);
    int unsigned sent;
    int unsigned burst_left;
    sent       = 0;
    burst_left = $urandom_range(1, 16);
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_round_trip(random_word(), random_word());
        sent += 2;
      end else begin
        send_block(op_e'($urandom_range(0, 1)), random_word(), random_word());
        sent++;
      end
      if (burst_left <= 1) begin
        // some gaps are zero so bursts also run back to back
        idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, max_gap));
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // key still at its reset value of zero
  task automatic test_reset_key();
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    idle_cycles(3);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);
    send_round_trip(32'hAAAA_AAAA, 32'h5555_5555);
    wait_for_drain();
  endtask

  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);
    send_round_trip(32'h0123_4567, 32'h89AB_CDEF);
    wait_for_drain();
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
    send_block(OP_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
    send_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    send_round_trip('1, '0);
    wait_for_drain();
    // rewrite one word only, the others must keep their values
    write_key_word(KEY_WORD_TWO, 32'hDEAD_BEEF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_block(OP_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
    send_round_trip(32'hFFFF_0000, 32'h0000_FFFF);
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    repeat (64) send_block(op_e'($urandom_range(0, 1)), $urandom(), $urandom());
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_key('0, '1, '0, '1);
        1: load_key('1, '1, '1, '1);
        default: load_key(random_word(), random_word(), random_word(), random_word());
      endcase
      run_traffic(95, 12);
      // hold off until the pipeline has fully emptied
      wait_for_drain();
      run_traffic(95, 4);
      wait_for_drain();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = KEY_WORD_ZERO;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    opcode_i      = OP_ENCRYPT;
    first_word_i  = '0;
    second_word_i = '0;
    error_count   = 0;
    for (int i = 0; i < KEY_WORDS; i++) key_copy[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_back_to_back();
    test_random_traffic();

    wait_for_drain();
    // catch any stray result after the last expected one
    repeat (2 * STAGE_COUNT + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
